[rtl/ssl_pkg.sv]
// ssl_pkg: shared types, codes and defaults for the sorted set block
// no dependencies; used by every file in rtl but ssl_ram

package ssl_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] key_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] entry_count;
    } t_out_word;

    typedef struct packed {
        logic precedes;
        logic equal;
    } t_cmp;

endpackage

[rtl/ssl_ram.sv]
// ssl_ram: generic single write, single read ram with registered read data
// no dependencies

module ssl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

[rtl/ssl_cmp.sv]
// ssl_cmp: shared order and equality compare used by the walk
// depends on ssl_pkg

module ssl_cmp (
    input  logic signed [31:0] i_entry,
    input  logic signed [31:0] i_key,
    input  logic               i_desc,
    output ssl_pkg::t_cmp      o_cmp
);

    always_comb begin
        o_cmp.equal    = (i_entry == i_key);
        o_cmp.precedes = i_desc ? (i_entry > i_key) : (i_entry < i_key);
    end

endmodule

[rtl/sorted_set_insert_remove_lookup.sv]
// sorted_set_insert_remove_lookup: top level, sequencer around the entry ram
// depends on ssl_pkg, ssl_ram, ssl_cmp
//
//   channel  direction  signals
//   in       input      i_in_valid, o_in_ready, i_in_word (operation, key_value)
//   out      output     o_out_valid, i_out_ready, o_out_word (status, entry_count)
//   cfg      input      i_cfg_valid, o_cfg_ready, i_cfg_data (order_descending)
//
// for n held entries, walk and shift together visit at most n+1 entries through the one
// ram port pair; a request also passes a decision state, a key write on insert and an
// output load
// reset is synchronous and clears the count, the order and the handshakes
// a new request is taken while a result still waits; a finished request holds
// until the output register is free

module sorted_set_insert_remove_lookup #(
    parameter int CAPACITY = ssl_pkg::CAPACITY_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ssl_pkg::t_in_word    i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ssl_pkg::t_out_word   o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WALK   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_INS    = 3'd3;
    localparam logic [2:0] S_PUT    = 3'd4;
    localparam logic [2:0] S_REM    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_pos, n_pos;
    logic [AW-1:0]      r_idx, n_idx;
    logic [1:0]         r_op, n_op;
    logic signed [31:0] r_key, n_key;
    logic               r_hit, n_hit;
    logic [1:0]         r_status, n_status;
    logic               r_desc;
    logic               r_out_valid, n_out_valid;
    ssl_pkg::t_out_word r_out, n_out;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;
    logic [AW-1:0]      rd_addr;
    logic [31:0]        rd_data;
    ssl_pkg::t_cmp      cmp;
    logic [CW-1:0]      pos_inc;
    logic [CW-1:0]      cnt_dec;

    ssl_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ssl_cmp u_cmp (
        .i_entry (rd_data),
        .i_key   (r_key),
        .i_desc  (r_desc),
        .o_cmp   (cmp)
    );

    assign pos_inc     = r_pos + CW'(1);
    assign cnt_dec     = r_count - CW'(1);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_op        = r_op;
        n_key       = r_key;
        n_hit       = r_hit;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = rd_data;
        rd_addr     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op  = i_in_word.operation;
                    n_key = i_in_word.key_value;
                    n_pos = '0;
                    n_hit = 1'b0;
                    n_state = (r_count == '0) ? S_DECIDE : S_WALK;
                end
            end
            S_WALK: begin
                if (cmp.precedes) begin
                    n_pos   = pos_inc;
                    rd_addr = pos_inc[AW-1:0];
                    if (pos_inc == r_count) begin
                        n_hit   = 1'b0;
                        n_state = S_DECIDE;
                    end
                end else begin
                    n_hit   = cmp.equal;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state  = S_DONE;
                n_status = r_hit ? ssl_pkg::ST_OK : ssl_pkg::ST_MISS;
                unique case (r_op)
                    ssl_pkg::OP_INSERT: begin
                        if (r_hit) begin
                            n_status = ssl_pkg::ST_MISS;
                        end else if (r_count == CW'(CAPACITY)) begin
                            n_status = ssl_pkg::ST_FULL;
                        end else begin
                            n_status = ssl_pkg::ST_OK;
                            if (r_pos == r_count) begin
                                n_state = S_PUT;
                            end else begin
                                n_idx   = cnt_dec[AW-1:0];
                                rd_addr = cnt_dec[AW-1:0];
                                n_state = S_INS;
                            end
                        end
                    end
                    ssl_pkg::OP_REMOVE: begin
                        if (r_hit) begin
                            if (pos_inc == r_count) begin
                                n_count = cnt_dec;
                            end else begin
                                n_idx   = pos_inc[AW-1:0];
                                rd_addr = pos_inc[AW-1:0];
                                n_state = S_REM;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_INS: begin
                wr_en   = 1'b1;
                wr_addr = r_idx + AW'(1);
                if (r_idx == r_pos[AW-1:0]) begin
                    n_state = S_PUT;
                end else begin
                    n_idx   = r_idx - AW'(1);
                    rd_addr = r_idx - AW'(1);
                end
            end
            S_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_pos[AW-1:0];
                wr_data = r_key;
                n_count = pos_inc == '0 ? r_count : r_count + CW'(1);
                n_state = S_DONE;
            end
            S_REM: begin
                wr_en   = 1'b1;
                wr_addr = r_idx - AW'(1);
                if (CW'(r_idx) == cnt_dec) begin
                    n_count = cnt_dec;
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    rd_addr = r_idx + AW'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.status      = r_status;
                    n_out.entry_count = 6'(r_count);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_desc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_desc <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_idx    <= n_idx;
        r_op     <= n_op;
        r_key    <= n_key;
        r_hit    <= n_hit;
        r_status <= n_status;
        r_out    <= n_out;
    end

endmodule

[rtl/ssl_chk.sv]
// ssl_chk: port level checks for the sorted set top level, and its bind
// depends on ssl_pkg and sorted_set_insert_remove_lookup

module ssl_chk #(
    parameter int CAPACITY = ssl_pkg::CAPACITY_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ssl_pkg::t_out_word o_out_word
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // the sequencer is busy in the cycle after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready held after accepting a word");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.status == ssl_pkg::ST_OK)
            || (o_out_word.status == ssl_pkg::ST_MISS)
            || (o_out_word.status == ssl_pkg::ST_FULL))
        else $error("unknown status code");

    // full is only reported on a table at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == ssl_pkg::ST_FULL
            |-> o_out_word.entry_count == 6'(CAPACITY))
        else $error("full status with table not at capacity");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (CAPACITY > 63) || (int'(o_out_word.entry_count) <= CAPACITY))
        else $error("entry count beyond capacity");

endmodule

bind sorted_set_insert_remove_lookup ssl_chk #(
    .CAPACITY (CAPACITY)
) u_ssl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

[dv/sorted_set_insert_remove_lookup_test.sv]
`timescale 1ns / 1ps
// sorted_set_insert_remove_lookup_test: self-checking testbench for the sorted set block
// depends on ssl_pkg and the sorted_set_insert_remove_lookup top level; drives lookups,
// inserts and removes in both orders and checks every result word against a shadow table

module sorted_set_insert_remove_lookup_test;

    import ssl_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in_word   i_in_word = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_word  o_out_word;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_data = 1'b0;

    // shadow copy of the table
    logic signed [31:0] shadow_keys [CAPACITY];
    int unsigned        shadow_total = 0;
    logic               shadow_descending = 1'b0;

    t_out_word pending_answers [$];

    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    int mismatches = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_full = 0;
    int n_dup_miss = 0;
    int peak_total = 0;

    sorted_set_insert_remove_lookup #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_word(i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word(o_out_word),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("** sorted_set_insert_remove_lookup: FAILED **");
        $finish;
    end

    function automatic logic key_precedes(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
        if (shadow_descending) begin
            return a > b;
        end
        return a < b;
    endfunction

    function automatic t_out_word apply_request(input t_in_word w);
        logic signed [31:0] key;
        int unsigned        pos;
        logic               hit;
        t_out_word          r;
        key = $signed(w.key_value);
        pos = 0;
        while (pos < shadow_total && key_precedes(shadow_keys[pos], key)) begin
            pos++;
        end
        hit = (pos < shadow_total) && (shadow_keys[pos] == key);
        case (w.operation)
            OP_INSERT: begin
                if (hit) begin
                    r.status = ST_MISS;
                end else if (shadow_total >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = shadow_total; i > pos; i--) begin
                        shadow_keys[i] = shadow_keys[i - 1];
                    end
                    shadow_keys[pos] = key;
                    shadow_total++;
                    r.status = ST_OK;
                end
            end
            OP_REMOVE: begin
                if (!hit) begin
                    r.status = ST_MISS;
                end else begin
                    for (int i = pos; i + 1 < shadow_total; i++) begin
                        shadow_keys[i] = shadow_keys[i + 1];
                    end
                    shadow_total--;
                    r.status = ST_OK;
                end
            end
            default: begin
                r.status = hit ? ST_OK : ST_MISS;
            end
        endcase
        r.entry_count = shadow_total[5:0];
        if (r.status == ST_FULL) begin
            n_full++;
        end
        if (r.status == ST_MISS) begin
            n_dup_miss++;
        end
        if (shadow_total > peak_total) begin
            peak_total = shadow_total;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_answer(input t_out_word got);
        t_out_word want;
        if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("result word with nothing pending: status %0d count %0d",
                                      got.status, got.entry_count));
        end else begin
            want = pending_answers.pop_front();
            n_checked++;
            if (got.status !== want.status) begin
                report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
            end
            if (got.entry_count !== want.entry_count) begin
                report_mismatch($sformatf("entry_count %0d, wanted %0d",
                                          got.entry_count, want.entry_count));
            end
        end
    endtask

    // result side: random stalls and checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            check_answer(o_out_word);
        end
        i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic send_request(input logic [1:0] op, input logic signed [31:0] key);
        t_in_word w;
        w.operation = op;
        w.key_value = key;
        if ($urandom_range(99) < tx_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_gap_pct);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        pending_answers.push_back(apply_request(w));
        n_sent++;
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_answers.size() != 0);
    endtask

    task automatic write_order(input logic descending);
        wait_for_results();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= descending;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shadow_descending = descending;
    endtask

    task automatic empty_table();
        while (shadow_total != 0) begin
            if ($urandom_range(1) == 0) begin
                send_request(OP_REMOVE, shadow_keys[0]);
            end else begin
                send_request(OP_REMOVE, shadow_keys[$urandom_range(shadow_total - 1)]);
            end
        end
    endtask

    task automatic test_basic_ops();
        write_order(1'b0);
        send_request(OP_LOOKUP, 32'sd0);
        send_request(OP_REMOVE, 32'sd5);
        send_request(OP_INSERT, KEY_MIN);
        send_request(OP_INSERT, KEY_MAX);
        send_request(OP_INSERT, 32'sd0);
        send_request(OP_INSERT, -32'sd1);
        send_request(OP_INSERT, 32'sd1);
        send_request(OP_INSERT, 32'sh5555_5555);
        send_request(OP_INSERT, 32'shaaaa_aaaa);
        send_request(OP_INSERT, 32'sd0);
        send_request(OP_LOOKUP, KEY_MIN);
        send_request(OP_LOOKUP, KEY_MAX);
        send_request(OP_LOOKUP, 32'sd2);
        send_request(OP_UNUSED, KEY_MAX);
        send_request(OP_UNUSED, 32'sd7);
        send_request(OP_REMOVE, -32'sd1);
        send_request(OP_REMOVE, -32'sd1);
        send_request(OP_REMOVE, KEY_MAX);
        send_request(OP_REMOVE, KEY_MIN);
        send_request(OP_LOOKUP, 32'shaaaa_aaaa);
        empty_table();
    endtask

    task automatic test_full_table();
        while (shadow_total < CAPACITY) begin
            send_request(OP_INSERT, $urandom);
        end
        send_request(OP_INSERT, $urandom);
        send_request(OP_INSERT, shadow_keys[5]);
        send_request(OP_LOOKUP, shadow_keys[CAPACITY - 1]);
        send_request(OP_REMOVE, shadow_keys[CAPACITY - 1]);
        send_request(OP_INSERT, KEY_MAX);
        send_request(OP_INSERT, KEY_MIN);
        empty_table();
    endtask

    // table left in ascending order, then searched as descending
    task automatic test_order_switch();
        send_request(OP_INSERT, -32'sd30);
        send_request(OP_INSERT, -32'sd10);
        send_request(OP_INSERT, 32'sd0);
        send_request(OP_INSERT, 32'sd10);
        send_request(OP_INSERT, 32'sd30);
        write_order(1'b1);
        send_request(OP_LOOKUP, -32'sd30);
        send_request(OP_LOOKUP, 32'sd10);
        send_request(OP_LOOKUP, 32'sd30);
        send_request(OP_INSERT, 32'sd20);
        send_request(OP_INSERT, -32'sd100);
        send_request(OP_REMOVE, 32'sd10);
        send_request(OP_REMOVE, -32'sd30);
        send_request(OP_INSERT, 32'sd0);
        empty_table();
        write_order(1'b0);
    endtask

    task automatic run_random_phase(input int items, input logic flip_midway);
        int          target;
        int          roll;
        logic [1:0]  op;
        logic signed [31:0] key;
        target = 0;
        for (int n = 0; n < items; n++) begin
            if (n % 40 == 0) begin
                target = ($urandom_range(3) == 0) ? CAPACITY + 2 : $urandom_range(CAPACITY);
            end
            if (n == items / 2) begin
                if (flip_midway) begin
                    write_order(!shadow_descending);
                end else begin
                    wait_for_results();
                end
            end
            roll = $urandom_range(99);
            if (roll < 4) begin
                op = OP_UNUSED;
            end else if (roll < 24) begin
                op = OP_LOOKUP;
            end else if ((roll < 80) == (shadow_total < target)) begin
                op = OP_INSERT;
            end else begin
                op = OP_REMOVE;
            end
            roll = $urandom_range(99);
            if (shadow_total != 0 && roll < ((op == OP_INSERT) ? 15 : 60)) begin
                key = shadow_keys[$urandom_range(shadow_total - 1)];
            end else begin
                roll = $urandom_range(99);
                if (roll < 50) begin
                    key = $urandom_range(16) - 8;
                end else if (roll < 60) begin
                    key = roll[0] ? KEY_MAX : KEY_MIN;
                end else begin
                    key = $urandom;
                end
            end
            send_request(op, key);
        end
    endtask

    initial begin
        tx_gap_pct   = 34;
        rx_stall_pct = 57;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_full_table();
        test_order_switch();
        run_random_phase(200, 1'b0);

        tx_gap_pct   = 57;
        rx_stall_pct = 34;
        write_order(1'b1);
        run_random_phase(200, 1'b0);

        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        run_random_phase(200, 1'b1);

        wait_for_results();
        repeat (2 * CAPACITY + 8) @(posedge i_clk);

        $display("sent %0d requests in both orders, checked %0d result words", n_sent, n_checked);
        $display("peak entries %0d, full refusals %0d, duplicate or missing %0d",
                 peak_total, n_full, n_dup_miss);
        if (mismatches == 0) begin
            $display("** sorted_set_insert_remove_lookup: PASSED **");
        end else begin
            $display("** sorted_set_insert_remove_lookup: FAILED **");
        end
        $finish;
    end

endmodule
